// ===== rtl/akf_pkg.sv =====
// ----------------------------------------------------------------------------
// akf_pkg
// Shared types, widths and constants of the angle Kalman filter.
// ----------------------------------------------------------------------------
package akf_pkg;

  // Q8.24 number format
  localparam int FRAC    = 24;
  localparam int ST_W    = 32;   // covariance entries
  localparam int ANG_W   = 27;   // angle state / output
  localparam int BIAS_W  = 25;   // bias state / output
  localparam int X_W     = 38;   // working angle before wrap
  localparam int MA_W    = 34;   // multiplier operand A
  localparam int MB_W    = 33;   // multiplier operand B
  localparam int PR_W    = MA_W + MB_W;
  localparam int RND_W   = PR_W - FRAC;
  localparam int SAT_W   = 44;
  localparam int INNOV_W = 29;
  localparam int S_W     = 33;
  localparam int DIV_NW  = 57;   // dividend bits, one quotient bit per cycle
  localparam int DIV_DW  = 33;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam logic signed [X_W-1:0]  PI_Q     = 38'sd52707179;
  localparam logic signed [X_W-1:0]  TWO_PI_Q = 38'sd105414358;
  localparam logic signed [X_W-1:0]  HALF_Q   = 38'sd8388608;
  localparam logic signed [ST_W-1:0] ONE_Q    = 32'sd16777216;

  // Multiple of 2pi for the angle wrap: reciprocal multiply, estimate is the
  // true count or one less, never more; |dividend| < 2^33 gives count < 128
  localparam int WRAP_SH = 58;
  localparam int WRAP_QW = 7;
  localparam logic signed [MB_W-1:0] WRAP_RECIP =
    MB_W'((64'd1 << WRAP_SH) / 64'd105414358);

  // Register map (word index)
  localparam logic [1:0] REG_AQ = 2'd0;
  localparam logic [1:0] REG_BQ = 2'd1;
  localparam logic [1:0] REG_R  = 2'd2;

  localparam logic [24:0] AQ_RST = 25'd16777;
  localparam logic [24:0] BQ_RST = 25'd50332;
  localparam logic [30:0] R_RST  = 31'd8388608;

  typedef struct packed {
    logic [24:0] aq;
    logic [24:0] bq;
    logic [30:0] r;
  } akf_cfg_t;

  typedef struct packed {
    logic               busy;
    logic [DIV_NW-1:0]  quo;
  } akf_div_st_t;

  typedef enum logic [4:0] {
    S_IDLE, S_M1, S_A1, S_WCHK, S_WDIV, S_WMUL,
    S_M2, S_A2, S_M3, S_A3, S_M4, S_A4,
    S_D0, S_D0W, S_D1, S_D1W,
    S_M5, S_A5, S_M6, S_A6,
    S_M7, S_A7, S_M8, S_A8, S_M9, S_A9, S_M10, S_A10,
    S_DONE
  } akf_state_t;

  // Saturate to 32-bit signed
  function automatic logic signed [ST_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [ST_W-1:0] r;
    if (v > 44'sd2147483647) r = 32'sh7FFF_FFFF;
    else if (v < -44'sd2147483648) r = 32'sh8000_0000;
    else r = v[ST_W-1:0];
    return r;
  endfunction

  // Signed, saturated gain from unsigned quotient
  function automatic logic signed [ST_W-1:0] qsat(input logic [DIV_NW-1:0] q,
                                                  input logic neg);
    logic signed [ST_W-1:0] r;
    if (q[DIV_NW-1:ST_W-1] != '0) r = neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    else r = neg ? -$signed(q[ST_W-1:0]) : $signed(q[ST_W-1:0]);
    return r;
  endfunction

endpackage

// ===== rtl/akf_if.sv =====
// ----------------------------------------------------------------------------
// akf_if
// Valid/ready channels for filter samples and estimates.
// ----------------------------------------------------------------------------
interface akf_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] gyro_rate;
  logic signed [26:0] measured_angle;
  logic        [23:0] time_step;

  modport source(output valid, gyro_rate, measured_angle, time_step, input ready);
  modport sink(input valid, gyro_rate, measured_angle, time_step, output ready);
endinterface

interface akf_out_if;
  logic               valid;
  logic               ready;
  logic signed [26:0] angle_estimate;
  logic signed [24:0] bias_estimate;

  modport source(output valid, angle_estimate, bias_estimate, input ready);
  modport sink(input valid, angle_estimate, bias_estimate, output ready);
endinterface

// ===== rtl/akf_mul.sv =====
// ----------------------------------------------------------------------------
// akf_mul
// Shared signed multiplier with registered product.
// ----------------------------------------------------------------------------
module akf_mul import akf_pkg::*; (
  input  logic                    clk,
  input  logic signed [MA_W-1:0]  a,
  input  logic signed [MB_W-1:0]  b,
  output logic signed [PR_W-1:0]  prod
);

  // product register, loaded every cycle
  always_ff @(posedge clk) begin
    prod <= PR_W'(a) * PR_W'(b);
  end

endmodule

// ===== rtl/akf_div.sv =====
// ----------------------------------------------------------------------------
// akf_div
// Shared restoring divider, unsigned, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module akf_div import akf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DIV_NW-1:0]  numer,
  input  logic [DIV_DW-1:0]  denom,
  output akf_div_st_t        st
);

  localparam int CNT_W = $clog2(DIV_NW + 1);

  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic [DIV_NW-1:0] quo;
  logic [DIV_DW-1:0] rem;
  logic [DIV_DW-1:0] den;
  logic [DIV_DW:0]   rem_sh;
  logic              ge;

  // one shift / compare / subtract step
  assign rem_sh = {rem, quo[DIV_NW-1]};
  assign ge     = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(DIV_NW);
    end else if (busy) begin
      cnt  <= cnt - 1'b1;
      busy <= (cnt != CNT_W'(1));
    end
  end

  // datapath: dividend shifts out as quotient shifts in
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= numer;
      rem <= '0;
      den <= denom;
    end else if (busy) begin
      quo <= {quo[DIV_NW-2:0], ge};
      rem <= ge ? DIV_DW'(rem_sh - {1'b0, den}) : rem_sh[DIV_DW-1:0];
    end
  end

  assign st.busy = busy;
  assign st.quo  = quo;

endmodule

// ===== rtl/akf_regs.sv =====
// ----------------------------------------------------------------------------
// akf_regs
// APB configuration registers: process and measurement noise.
// ----------------------------------------------------------------------------
module akf_regs import akf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output akf_cfg_t          cfg
);

  logic       wr_en;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[3:2];

  // register write
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.aq <= AQ_RST;
      cfg.bq <= BQ_RST;
      cfg.r  <= R_RST;
    end else if (wr_en) begin
      case (idx)
        REG_AQ:  cfg.aq <= pwdata[24:0];
        REG_BQ:  cfg.bq <= pwdata[24:0];
        REG_R:   cfg.r  <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_AQ:  prdata = DATA_W'(cfg.aq);
      REG_BQ:  prdata = DATA_W'(cfg.bq);
      REG_R:   prdata = DATA_W'(cfg.r);
      default: prdata = '0;
    endcase
  end

endmodule

// ===== rtl/angle_kalman_filter_top.sv =====
// ----------------------------------------------------------------------------
// angle_kalman_filter_top
// Two-state (angle, gyro bias) Kalman filter, Q8.24, run by a small sequencer
// over one shared multiplier and one shared bit-serial divider.
// ----------------------------------------------------------------------------
// Sequence: an accepted word runs through the prediction products, the two gain
//   divisions and the update products; each angle wrap adds correction passes.
//   The two gain divisions dominate.
// Flow: one word at a time, plus any output stall; the next word is taken
//   once the estimate is registered, even while it waits.
// Reset: synchronous; clears state, covariance to identity, noise registers
//   to their defaults.
module angle_kalman_filter_top import akf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  akf_in_if.sink            in_ch,
  akf_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam logic signed [PR_W-1:0] RND_HALF = PR_W'(1) << (FRAC - 1);

  akf_state_t state, state_next;
  akf_cfg_t   cfg;
  akf_div_st_t div_st;

  // filter state
  logic signed [ANG_W-1:0]  ang;
  logic signed [BIAS_W-1:0] bias;
  logic signed [ST_W-1:0]   p00, p01, p10, p11;
  logic                     out_valid;

  // per-word working registers
  logic signed [31:0]       rate;
  logic signed [26:0]       meas;
  logic        [23:0]       dt;
  logic signed [X_W-1:0]    x;
  logic                     phase;
  logic                     wneg;
  logic                     qneg;
  logic signed [S_W-1:0]    p11dt;
  logic signed [ST_W-1:0]   p00n, p01n, p10n, p11n;
  logic signed [INNOV_W-1:0] innov;
  logic signed [S_W-1:0]    s;
  logic signed [ST_W-1:0]   k0, k1;
  logic signed [BIAS_W-1:0] bt;

  // shared units
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PR_W-1:0]   prod;
  logic                     div_start;
  logic [DIV_NW-1:0]        div_num;
  logic [DIV_DW-1:0]        div_den;

  logic signed [PR_W-1:0]   prod_r;
  logic signed [RND_W-1:0]  rnd;
  logic signed [X_W-1:0]    rnd_x;
  logic signed [BIAS_W:0]   dt_s;
  logic                     wr_hi, wr_lo;
  logic signed [X_W-1:0]    wr_num;
  logic [WRAP_QW-1:0]       wq_est;
  logic [WRAP_QW-1:0]       wq;
  logic signed [ST_W-1:0]   qn;
  logic [ST_W-1:0]          qn_abs;
  logic [DIV_DW-1:0]        s_abs;
  logic signed [INNOV_W-1:0] innov_raw;
  logic signed [X_W-1:0]    bsum;
  logic                     in_acc;

  akf_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready, .cfg
  );

  akf_mul u_mul (.clk, .a(mul_a), .b(mul_b), .prod);

  akf_div u_div (
    .clk, .rst, .start(div_start), .numer(div_num), .denom(div_den), .st(div_st)
  );

  // rounding of the registered product, half toward +inf
  assign prod_r = prod + RND_HALF;
  assign rnd    = prod_r[PR_W-1:FRAC];
  assign rnd_x  = rnd[X_W-1:0];
  assign dt_s   = $signed({2'b0, dt});

  // wrap test and dividend for the multiple of 2pi
  assign wr_hi  = x > PI_Q;
  assign wr_lo  = x < -PI_Q;
  assign wr_num = wr_hi ? x + PI_Q - X_W'(1) : PI_Q - X_W'(1) - x;

  // multiple of 2pi from the reciprocal product; at least one when out of range
  assign wq_est = prod[WRAP_SH+WRAP_QW-1:WRAP_SH];
  assign wq     = (wq_est == '0) ? WRAP_QW'(1) : wq_est;

  // gain numerator and |S|
  assign qn     = (state == S_D0) ? p00n : p10n;
  assign qn_abs = qn[ST_W-1] ? ST_W'(-qn) : ST_W'(qn);
  assign s_abs  = s[S_W-1] ? DIV_DW'(-s) : DIV_DW'(s);

  // innovation before wrap, bias sum before clamp
  assign innov_raw = INNOV_W'(meas) - INNOV_W'(x);
  assign bsum      = X_W'(bias) + rnd_x;

  assign in_acc       = in_ch.valid & in_ch.ready;
  assign out_ch.valid = out_valid;
  assign out_ch.angle_estimate = ang;
  assign out_ch.bias_estimate  = bias;

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // next state, unit operands
  always_comb begin
    state_next  = state;
    in_ch.ready = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    div_start   = 1'b0;
    div_num     = '0;
    div_den     = '0;
    case (state)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) state_next = S_M1;
      end
      S_M1: begin
        mul_a = MA_W'(rate) - MA_W'(bias);
        mul_b = MB_W'(dt_s);
        state_next = S_A1;
      end
      S_A1: state_next = S_WCHK;
      S_WCHK: begin
        if (wr_hi || wr_lo) begin
          mul_a      = MA_W'(wr_num);
          mul_b      = WRAP_RECIP;
          state_next = S_WDIV;
        end else begin
          state_next = phase ? S_M6 : S_M2;
        end
      end
      S_WDIV: begin
        mul_a = MA_W'($signed({1'b0, wq}));
        mul_b = MB_W'(TWO_PI_Q);
        state_next = S_WMUL;
      end
      S_WMUL: state_next = S_WCHK;
      S_M2: begin
        mul_a = MA_W'(p11);
        mul_b = MB_W'(dt_s);
        state_next = S_A2;
      end
      S_A2: state_next = S_M3;
      S_M3: begin
        mul_a = MA_W'(p11dt) - MA_W'(p01) - MA_W'(p10) + MA_W'($signed({1'b0, cfg.aq}));
        mul_b = MB_W'(dt_s);
        state_next = S_A3;
      end
      S_A3: state_next = S_M4;
      S_M4: begin
        mul_a = MA_W'($signed({1'b0, cfg.bq}));
        mul_b = MB_W'(dt_s);
        state_next = S_A4;
      end
      S_A4: state_next = S_D0;
      S_D0, S_D1: begin
        if (s != '0) begin
          div_start = 1'b1;
          div_num   = (DIV_NW'(qn_abs) << FRAC) + DIV_NW'(s_abs >> 1);
          div_den   = s_abs;
        end
        state_next = (state == S_D0) ? S_D0W : S_D1W;
      end
      S_D0W: if (!div_st.busy) state_next = S_D1;
      S_D1W: if (!div_st.busy) state_next = S_M5;
      S_M5: begin
        mul_a = MA_W'(innov);
        mul_b = MB_W'(k0);
        state_next = S_A5;
      end
      S_A5: state_next = S_WCHK;
      S_M6: begin
        mul_a = MA_W'(innov);
        mul_b = MB_W'(k1);
        state_next = S_A6;
      end
      S_A6: state_next = S_M7;
      S_M7: begin
        mul_a = MA_W'(p00n);
        mul_b = MB_W'(k0);
        state_next = S_A7;
      end
      S_A7: state_next = S_M8;
      S_M8: begin
        mul_a = MA_W'(p01n);
        mul_b = MB_W'(k0);
        state_next = S_A8;
      end
      S_A8: state_next = S_M9;
      S_M9: begin
        mul_a = MA_W'(p00n);
        mul_b = MB_W'(k1);
        state_next = S_A9;
      end
      S_A9: state_next = S_M10;
      S_M10: begin
        mul_a = MA_W'(p01n);
        mul_b = MB_W'(k1);
        state_next = S_A10;
      end
      S_A10: state_next = S_DONE;
      S_DONE: if (!out_valid || out_ch.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || out_ch.ready)) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // filter state: angle, bias, covariance
  always_ff @(posedge clk) begin
    if (rst) begin
      ang  <= '0;
      bias <= '0;
      p00  <= ONE_Q;
      p01  <= '0;
      p10  <= '0;
      p11  <= ONE_Q;
    end else begin
      case (state)
        S_A7:   p00 <= sat32(SAT_W'(p00n) - SAT_W'(rnd));
        S_A8:   p01 <= sat32(SAT_W'(p01n) - SAT_W'(rnd));
        S_A9:   p10 <= sat32(SAT_W'(p10n) - SAT_W'(rnd));
        S_A10:  p11 <= sat32(SAT_W'(p11n) - SAT_W'(rnd));
        S_DONE: begin
          if (!out_valid || out_ch.ready) begin
            ang  <= x[ANG_W-1:0];
            bias <= bt;
          end
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rate <= in_ch.gyro_rate;
      meas <= in_ch.measured_angle;
      dt   <= in_ch.time_step;
    end
    case (state)
      S_A1: begin
        x     <= X_W'(ang) + rnd_x;
        phase <= 1'b0;
      end
      S_WCHK: wneg <= wr_lo;
      S_WMUL: x <= wneg ? x + prod[X_W-1:0] : x - prod[X_W-1:0];
      S_A2:   p11dt <= rnd[S_W-1:0];
      S_A3: begin
        p00n <= sat32(SAT_W'(p00) + SAT_W'(rnd));
        p01n <= sat32(SAT_W'(p01) - SAT_W'(p11dt));
        p10n <= sat32(SAT_W'(p10) - SAT_W'(p11dt));
      end
      S_A4: begin
        p11n <= sat32(SAT_W'(p11) + SAT_W'(rnd));
        if (innov_raw > PI_Q) innov <= innov_raw - INNOV_W'(TWO_PI_Q);
        else if (innov_raw < -PI_Q) innov <= innov_raw + INNOV_W'(TWO_PI_Q);
        else innov <= innov_raw;
        s <= S_W'(p00n) + S_W'($signed({1'b0, cfg.r}));
      end
      S_D0, S_D1: begin
        qneg <= qn[ST_W-1] ^ s[S_W-1];
        if (s == '0) begin
          if (state == S_D0) k0 <= '0;
          else k1 <= '0;
        end
      end
      S_D0W: if (!div_st.busy && s != '0) k0 <= qsat(div_st.quo, qneg);
      S_D1W: if (!div_st.busy && s != '0) k1 <= qsat(div_st.quo, qneg);
      S_A5: begin
        x     <= x + rnd_x;
        phase <= 1'b1;
      end
      S_A6: begin
        if (bsum > HALF_Q) bt <= BIAS_W'(HALF_Q);
        else if (bsum < -HALF_Q) bt <= BIAS_W'(-HALF_Q);
        else bt <= bsum[BIAS_W-1:0];
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  // a published angle always lies within [-pi, pi]
  a_ang_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (X_W'(ang) <= PI_Q && X_W'(ang) >= -PI_Q))
    else $error("angle estimate out of range");

  // an accepted word starts the sequencer
  a_start: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> state == S_M1)
    else $error("sequencer did not start");

  // the divider is never restarted while busy
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_st.busy)
    else $error("divider restarted while busy");

  // a finished word waits while the previous estimate is pending
  a_done_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_valid && !out_ch.ready) |=> state == S_DONE)
    else $error("estimate overwritten");
`endif

endmodule

// ===== verif/angle_kalman_filter_top_tb.sv =====
// ----------------------------------------------------------------------------
// angle_kalman_filter_top_tb
// Self-checking bench for the angle/bias Kalman filter. A fixed-point
// predictor in the scoreboard tracks the filter state and covariance. Each
// accepted sample word is predicted; each estimate word is checked in order.
// The bench sweeps several noise settings, bursty input and a stalling output.
// ----------------------------------------------------------------------------
module angle_kalman_filter_top_tb;
  import akf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CYCLE_LIMIT = 3000000;
  localparam int     DRAIN_CYCLES = 400;
  localparam int     HOLD_CYCLES = 3000;

  // Kalman filter predictor and queue of expected estimates
  class kalman_scoreboard;
    typedef struct {
      logic signed [26:0] angle;
      logic signed [24:0] bias;
    } estimate_t;

    longint    aq, bq, rn;
    longint    ang, bias, c00, c01, c10, c11;
    estimate_t pending_q[$];
    int        errors;

    function void init();
      aq = longint'(AQ_RST); bq = longint'(BQ_RST); rn = longint'(R_RST);
      ang = 0; bias = 0; c00 = longint'(ONE_Q); c01 = 0; c10 = 0;
      c11 = longint'(ONE_Q);
      errors = 0;
    endfunction

    function void set_reg(int idx, logic [31:0] val);
      case (idx)
        REG_AQ: aq = longint'(val[24:0]);
        REG_BQ: bq = longint'(val[24:0]);
        REG_R:  rn = longint'(val[30:0]);
        default: ;
      endcase
    endfunction

    function longint sat(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    // exact product, rounded half up to FRAC fraction bits
    function longint fmul(longint a, longint b);
      return (a * b + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
    endfunction

    // rounded, saturated quotient; zero divisor gives zero gain
    function longint fdiv(longint n, longint d);
      bit     neg;
      longint un, ud, q;
      if (d == 0) return 0;
      neg = (n < 0) != (d < 0);
      un = n < 0 ? -n : n;
      ud = d < 0 ? -d : d;
      q = ((un <<< FRAC) + ud / 2) / ud;
      if (q > 64'sd2147483647) q = neg ? 64'sd2147483648 : 64'sd2147483647;
      return neg ? -q : q;
    endfunction

    function longint wrap_pi(longint x);
      longint pq, tq, n;
      pq = longint'(PI_Q); tq = longint'(TWO_PI_Q);
      if (x > pq) begin
        n = (x - pq + tq - 1) / tq;
        x -= n * tq;
      end else if (x < -pq) begin
        n = (-pq - x + tq - 1) / tq;
        x += n * tq;
      end
      return x;
    endfunction

    function void note_sample(logic signed [31:0] g, logic signed [26:0] m,
                              logic [23:0] t);
      longint    rate, meas, dt, p00, p01, p10, p11, p11dt, innov, s, k0, k1;
      longint    a, b, pq, tq;
      estimate_t e;
      rate = longint'(g); meas = longint'(m); dt = longint'(t);
      pq = longint'(PI_Q); tq = longint'(TWO_PI_Q);
      // prediction
      a = wrap_pi(ang + fmul(dt, rate - bias));
      p11dt = fmul(dt, c11);
      p00 = sat(c00 + fmul(dt, p11dt - c01 - c10 + aq));
      p01 = sat(c01 - p11dt);
      p10 = sat(c10 - p11dt);
      p11 = sat(c11 + fmul(bq, dt));
      // update, innovation wrapped only once
      innov = meas - a;
      if (innov > pq) innov -= tq;
      if (innov < -pq) innov += tq;
      s = p00 + rn;
      k0 = fdiv(p00, s);
      k1 = fdiv(p10, s);
      a = wrap_pi(a + fmul(k0, innov));
      b = bias + fmul(k1, innov);
      if (b > longint'(HALF_Q)) b = longint'(HALF_Q);
      if (b < -longint'(HALF_Q)) b = -longint'(HALF_Q);
      c00 = sat(p00 - fmul(k0, p00));
      c01 = sat(p01 - fmul(k0, p01));
      c10 = sat(p10 - fmul(k1, p00));
      c11 = sat(p11 - fmul(k1, p01));
      ang = sat(a);
      bias = b;
      e.angle = ang[26:0];
      e.bias = bias[24:0];
      pending_q.push_back(e);
    endfunction

    function void check_estimate(logic signed [26:0] a, logic signed [24:0] b);
      estimate_t e;
      if (pending_q.size() == 0) begin
        $error("estimate word with none expected: angle %0d bias %0d", a, b);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (a !== e.angle) begin
        $error("angle_estimate: expected %0d, actual %0d", e.angle, a);
        errors++;
      end
      if (b !== e.bias) begin
        $error("bias_estimate: expected %0d, actual %0d", e.bias, b);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [DATA_W-1:0]  pwdata = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  akf_in_if  in_ch();
  akf_out_if out_ch();

  angle_kalman_filter_top i_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  kalman_scoreboard sb = new();
  longint cycle_cnt = 0;
  bit     hold_req = 1'b0;
  int     burst_left = 0;
  int     gap_max = 6;

  always #1 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("angle_kalman_filter_top_tb: errors");
      $finish;
    end
  end

  // check estimate words
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      sb.check_estimate(out_ch.angle_estimate, out_ch.bias_estimate);
  end

  // output stall pattern, with one long hold-off on request
  initial begin
    int mode, span;
    out_ch.ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 300);
      repeat (span) begin
        @(negedge clk);
        if (hold_req) begin
          out_ch.ready = 1'b0;
          repeat (HOLD_CYCLES - 1) @(negedge clk);
          hold_req = 1'b0;
        end
        case (mode)
          0: out_ch.ready = 1'b1;
          1: out_ch.ready = cycle_cnt[0];
          2: out_ch.ready = ($urandom_range(0, 9) < 3);
          default: out_ch.ready = ($urandom_range(0, 9) < 8);
        endcase
      end
    end
  end

  task automatic reg_write(int idx, logic [31:0] val);
    @(negedge clk);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = ADDR_W'(idx * 4); pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  // offer one sample word; valid stays high into the next word of a burst
  task automatic send_sample(logic signed [31:0] g, logic signed [26:0] m,
                             logic [23:0] t);
    int gap;
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.gyro_rate = g; in_ch.measured_angle = m; in_ch.time_step = t;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_sample(g, m, t);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        @(negedge clk);
        in_ch.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // stop offering words and wait for the block to finish everything in flight
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    wait (sb.pending_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_samples(int count);
    logic signed [31:0] g;
    logic signed [26:0] m;
    logic [23:0]        t;
    repeat (count) begin
      if ($urandom_range(0, 99) < 80) begin
        // plausible motion: short steps, moderate rates, angle in range
        t = 24'($urandom_range(0, 838861));
        g = $signed($urandom_range(0, 2 * 100663296)) - 100663296;
        m = 27'($signed($urandom_range(0, 2 * 52707179)) - 52707179);
      end else begin
        g = $urandom;
        m = 27'($urandom);
        t = 24'($urandom);
      end
      send_sample(g, m, t);
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.gyro_rate = '0; in_ch.measured_angle = '0; in_ch.time_step = '0;
    sb.init();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: field extremes and wrap corners at reset noise settings
    send_sample(32'sh7FFF_FFFF, 27'sd0, 24'd0);
    send_sample(32'sh8000_0000, 27'sd0, 24'hFF_FFFF);
    send_sample(32'sh7FFF_FFFF, 27'sd0, 24'hFF_FFFF);
    send_sample(32'sd0, 27'sd52707179, 24'hFF_FFFF);
    send_sample(32'sd0, -27'sd52707179, 24'hFF_FFFF);
    send_sample(32'sd0, 27'sh3FF_FFFF, 24'd0);
    send_sample(32'sd0, 27'sh400_0000, 24'd167772);
    send_sample(32'sh8000_0000, 27'sh3FF_FFFF, 24'hFF_FFFF);
    send_sample(32'sd0, 27'sd0, 24'd0);
    send_sample(32'sd16777216, 27'sd52707180, 24'd167772);
    send_sample(-32'sd16777216, -27'sd52707180, 24'd167772);
    send_sample(32'sd0, 27'sd0, 24'd1);
    drain();
    // register index beyond the map is ignored
    reg_write(3, 32'hFFFF_FFFF);
    // zero measurement noise
    reg_write(REG_R, 32'd0);
    send_sample(32'sd0, 27'sd52707179, 24'd0);
    send_sample(32'sd1000, -27'sd52707179, 24'hFF_FFFF);
    send_sample(32'sd0, 27'sd0, 24'd0);
    drain();

    // noise sweep: maximum, minimum, random and reset values
    reg_write(REG_AQ, 32'd16777216);
    reg_write(REG_BQ, 32'd16777216);
    reg_write(REG_R, 32'd1677722);
    random_samples(230);
    drain();
    reg_write(REG_AQ, 32'd0);
    reg_write(REG_BQ, 32'd0);
    reg_write(REG_R, 32'h7FFF_FFFF);
    random_samples(230);
    drain();
    reg_write(REG_AQ, $urandom);
    reg_write(REG_BQ, $urandom);
    reg_write(REG_R, $urandom);
    // long output hold-off while words keep coming
    hold_req = 1'b1;
    random_samples(230);
    drain();
    reg_write(REG_AQ, 32'h1FF_FFFF);
    reg_write(REG_BQ, 32'h1FF_FFFF);
    reg_write(REG_R, 32'd1677722 + $urandom_range(0, 1000000));
    gap_max = 0;
    random_samples(230);
    drain();
    reg_write(REG_AQ, 32'(AQ_RST));
    reg_write(REG_BQ, 32'(BQ_RST));
    reg_write(REG_R, 32'(R_RST));
    gap_max = 6;
    random_samples(230);
    drain();
    reg_write(REG_AQ, $urandom_range(0, 16777216));
    reg_write(REG_BQ, $urandom_range(0, 16777216));
    reg_write(REG_R, $urandom_range(1677722, 2147483647));
    gap_max = 12;
    random_samples(240);

    @(negedge clk);
    in_ch.valid = 1'b0;
    drain();
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("angle_kalman_filter_top_tb: clean");
    end else begin
      $display("angle_kalman_filter_top_tb: errors");
    end
    $finish;
  end

endmodule
